// ===== src/pol_pkg.sv =====
`default_nettype none

package pol_pkg;

  // Sizing of the list store.
  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the two channels.
  localparam int FUNC_W   = 3;
  localparam int EID_W    = 32;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 3;
  localparam int FOUND_W  = 4;
  localparam int OCC_W    = 5;

  // Request codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_FRONT = 3'd0,
    FN_ADD_BACK  = 3'd1,
    FN_INSERT_AT = 3'd2,
    FN_REM_FIRST = 3'd3,
    FN_REM_LAST  = 3'd4,
    FN_REM_AT    = 3'd5,
    FN_SEARCH    = 3'd6,
    FN_OVERWRITE = 3'd7
  } func_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [IDX_W-1:0]   pos;
    logic [ID_BITS-1:0] id;
    logic [CNT_W-1:0]   count;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/pol_cell.sv =====
`default_nettype none

module pol_cell (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [pol_pkg::IDX_W-1:0]      cell_idx,
  input  pol_pkg::cell_ctl_t             ctl,
  input  wire  [pol_pkg::ID_BITS-1:0]    left_entry,
  input  wire  [pol_pkg::ID_BITS-1:0]    right_entry,
  output logic [pol_pkg::ID_BITS-1:0]    entry,
  output logic                           match
);
  import pol_pkg::*;

  logic [ID_BITS-1:0] entry_r;
  logic [ID_BITS-1:0] entry_nxt;
  logic               match_r;
  logic               match_nxt;

  // Next entry: shift from a neighbor, take the new identifier, or hold.
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.cmd)
      CELL_INSERT: begin
        if (cell_idx > ctl.pos) begin
          entry_nxt = left_entry;
        end else if (cell_idx == ctl.pos) begin
          entry_nxt = ctl.id;
        end
      end
      CELL_DELETE: begin
        if (cell_idx >= ctl.pos) begin
          entry_nxt = right_entry;
        end
      end
      CELL_WRITE: begin
        if (cell_idx == ctl.pos) begin
          entry_nxt = ctl.id;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // Only occupied cells may report a match.
  assign match_nxt = (entry_r == ctl.id) && ({1'b0, cell_idx} < ctl.count);

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

`default_nettype wire

// ===== src/pol_ctrl.sv =====
`default_nettype none

module pol_ctrl (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [pol_pkg::FUNC_W-1:0]     in_func,
  input  wire  [pol_pkg::EID_W-1:0]      in_entry_id,
  input  wire  [pol_pkg::POS_W-1:0]      in_position,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [pol_pkg::STAT_W-1:0]     out_status,
  output logic [pol_pkg::FOUND_W-1:0]    out_found_position,
  output logic [pol_pkg::OCC_W-1:0]      out_occupancy,
  output pol_pkg::cell_ctl_t             ctl,
  input  wire  [pol_pkg::CAPACITY-1:0]   match_vec
);
  import pol_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r;
  logic [ID_BITS-1:0] id_r;
  logic [POS_W-1:0]   pos_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  status_t            stat_r, stat_nxt;
  logic               search_r, search_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r;
  logic [FOUND_W-1:0] out_found_position_r;
  logic [OCC_W-1:0]   out_occupancy_r;

  cell_cmd_t          cmd;
  logic [CNT_W-1:0]   op_pos;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               in_fire;
  logic               resp_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  // Decode the captured request against the current occupancy.
  always_comb begin
    cmd        = CELL_HOLD;
    op_pos     = '0;
    stat_nxt   = STAT_OK;
    search_nxt = 1'b0;
    count_nxt  = count_r;
    unique case (func_t'(func_r))
      FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT_AT: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          stat_nxt = STAT_FULL;
        end else if (func_t'(func_r) == FN_ADD_FRONT) begin
          cmd = CELL_INSERT;
        end else if (func_t'(func_r) == FN_ADD_BACK) begin
          cmd    = CELL_INSERT;
          op_pos = count_r;
        end else if (CNT_W'(pos_r) > count_r) begin
          stat_nxt = STAT_BADPOS;
        end else begin
          cmd    = CELL_INSERT;
          op_pos = CNT_W'(pos_r);
        end
        if (cmd == CELL_INSERT) begin
          count_nxt = count_r + 1'b1;
        end
      end
      FN_REM_FIRST, FN_REM_LAST, FN_REM_AT: begin
        if (count_r == '0) begin
          stat_nxt = STAT_EMPTY;
        end else if (func_t'(func_r) == FN_REM_FIRST) begin
          cmd = CELL_DELETE;
        end else if (func_t'(func_r) == FN_REM_LAST) begin
          cmd    = CELL_DELETE;
          op_pos = count_r - 1'b1;
        end else if (CNT_W'(pos_r) >= count_r) begin
          stat_nxt = STAT_BADPOS;
        end else begin
          cmd    = CELL_DELETE;
          op_pos = CNT_W'(pos_r);
        end
        if (cmd == CELL_DELETE) begin
          count_nxt = count_r - 1'b1;
        end
      end
      FN_SEARCH: begin
        if (count_r == '0) begin
          stat_nxt = STAT_EMPTY;
        end else begin
          search_nxt = 1'b1;
        end
      end
      FN_OVERWRITE: begin
        if (count_r == '0) begin
          stat_nxt = STAT_EMPTY;
        end else if (CNT_W'(pos_r) >= count_r) begin
          stat_nxt = STAT_BADPOS;
        end else begin
          cmd    = CELL_WRITE;
          op_pos = CNT_W'(pos_r);
        end
      end
      default: begin
        stat_nxt = STAT_OK;
      end
    endcase
  end

  // The cells act only in the execute cycle; otherwise they hold and compare.
  always_comb begin
    ctl.cmd   = (state_r == S_EXEC) ? cmd : CELL_HOLD;
    ctl.pos   = op_pos[IDX_W-1:0];
    ctl.id    = id_r;
    ctl.count = count_r;
  end

  // Lowest matching position wins.
  always_comb begin
    hit     = |match_vec;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (resp_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (resp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_EXEC) begin
        count_r <= count_nxt;
      end
    end
  end

  // Request capture and decision.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      id_r   <= in_entry_id[ID_BITS-1:0];
      pos_r  <= in_position;
    end
    if (state_r == S_EXEC) begin
      stat_r   <= stat_nxt;
      search_r <= search_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_occupancy_r <= OCC_W'(count_r);
      if (search_r && hit) begin
        out_status_r         <= STAT_OK;
        out_found_position_r <= FOUND_W'(hit_idx);
      end else if (search_r) begin
        out_status_r         <= STAT_NOTFOUND;
        out_found_position_r <= '0;
      end else begin
        out_status_r         <= stat_r;
        out_found_position_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_position_r;
  assign out_occupancy      = out_occupancy_r;

endmodule

`default_nettype wire

// ===== src/positional_ordered_list.sv =====
// A request passes through capture, cell update and the result register.
// The next request is accepted only once the previous result is loaded;
// the result register lets the next request enter while a result waits.
// Every cell shifts, writes and compares in the same cycle, so all operations
// take the same time regardless of position or occupancy.
// Reset (synchronous, active low) empties the list; stored entries keep junk.
`default_nettype none

module positional_ordered_list (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [pol_pkg::FUNC_W-1:0]     in_func,
  input  wire  [pol_pkg::EID_W-1:0]      in_entry_id,
  input  wire  [pol_pkg::POS_W-1:0]      in_position,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [pol_pkg::STAT_W-1:0]     out_status,
  output logic [pol_pkg::FOUND_W-1:0]    out_found_position,
  output logic [pol_pkg::OCC_W-1:0]      out_occupancy
);
  import pol_pkg::*;

  cell_ctl_t          ctl;
  logic [ID_BITS-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0] match_vec;

  pol_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_entry_id        (in_entry_id),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_occupancy      (out_occupancy),
    .ctl                (ctl),
    .match_vec          (match_vec)
  );

  // Chain of cells; position 0 at the left end.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_BITS-1:0] left_entry;
    logic [ID_BITS-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_inner_l
      assign left_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner_r
      assign right_entry = entry[i+1];
    end

    pol_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (IDX_W'(i)),
      .ctl         (ctl),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[i]),
      .match       (match_vec[i])
    );
  end

endmodule

`default_nettype wire

// ===== src/pol_checker.sv =====
`default_nettype none

module pol_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [pol_pkg::STAT_W-1:0]      out_status,
  input wire [pol_pkg::FOUND_W-1:0]     out_found_position,
  input wire [pol_pkg::OCC_W-1:0]       out_occupancy
);
  import pol_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_position) && $stable(out_occupancy))
    else $error("result changed while stalled");

  // One request at a time: no new transaction right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // Occupancy never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  // Empty status goes with an empty list, and only success reports a position.
  a_status_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != STAT_EMPTY || out_occupancy == '0)
      && (out_status == STAT_OK || out_found_position == '0))
    else $error("status inconsistent with occupancy or position");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (.*);

`default_nettype wire
